>>> rtl/core/trs_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helpers for the TRS transform compose block.
// No dependencies; imported by trs_vrot and trs_transform_compose_unit.
package trs_pkg;

    localparam int LANE_W     = 16;
    localparam int VEC_LANES  = 3;
    localparam int QUAT_LANES = 4;
    localparam int NUM_STAGES = 6;

    // Datapath widths (signed), sized to the exact ranges of each product and sum
    localparam int PROD_W    = 32;   // 16 x 16 product
    localparam int SC_SUM_W  = 33;   // scale product plus rounding bias
    localparam int ROT_SUM_W = 34;   // four-term Hamilton sum
    localparam int TP_W      = 48;   // quaternion lane x Q.16 vector lane
    localparam int T_W       = 34;   // q x v after the Q1.14 shift
    localparam int UP_W      = 50;   // quaternion lane x t lane
    localparam int US_W      = 52;   // doubled three-term sum
    localparam int U_W       = 38;   // u after the Q1.14 shift
    localparam int SAT_IN_W  = 40;   // widest value handed to the clamp

    localparam int Q_SHIFT  = 14;
    localparam int QS_SHIFT = 8;

    localparam logic signed [SAT_IN_W-1:0] SAT_MAX = 40'sd32767;
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN = -40'sd32768;
    localparam logic [LANE_W-1:0] LANE_MAX = 16'h7FFF;
    localparam logic [LANE_W-1:0] LANE_MIN = 16'h8000;

    typedef logic signed [LANE_W-1:0] t_lane;

    typedef struct packed {
        logic [LANE_W-1:0] val;
        logic              ovf;
    } t_sat;

    // Per-stage load enables, stage 0 nearest the input
    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
    } t_pipe_ctl;

    // Clamp to a 16-bit lane and flag the clamp
    function automatic t_sat sat16(input logic signed [SAT_IN_W-1:0] a);
        t_sat r;
        if (a > SAT_MAX) begin
            r.val = LANE_MAX;
            r.ovf = 1'b1;
        end else if (a < SAT_MIN) begin
            r.val = LANE_MIN;
            r.ovf = 1'b1;
        end else begin
            r.val = a[LANE_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/trs_vrot.sv
`timescale 1ns / 1ps
// Translation path: scales the child translation, rotates it by the parent
// quaternion and adds the parent translation. Six stages; uses trs_pkg.
module trs_vrot (
    input  logic                                   i_clk,
    input  trs_pkg::t_pipe_ctl                     i_ctl,
    input  logic [trs_pkg::VEC_LANES*trs_pkg::LANE_W-1:0]  i_child_translation,
    input  logic [trs_pkg::VEC_LANES*trs_pkg::LANE_W-1:0]  i_parent_scale,
    input  logic [trs_pkg::VEC_LANES*trs_pkg::LANE_W-1:0]  i_parent_translation,
    input  logic [trs_pkg::QUAT_LANES*trs_pkg::LANE_W-1:0] i_parent_rotation,
    output logic [trs_pkg::VEC_LANES*trs_pkg::LANE_W-1:0]  o_translation,
    output logic                                   o_overflow
);
    import trs_pkg::*;

    t_lane w_ct [VEC_LANES];
    t_lane w_ps [VEC_LANES];
    t_lane w_pt [VEC_LANES];
    t_lane w_pq [QUAT_LANES];

    // Carried operands, indexed by stage
    logic signed [PROD_W-1:0] r_v  [NUM_STAGES-1][VEC_LANES];
    t_lane                    r_pt [NUM_STAGES-1][VEC_LANES];
    t_lane                    r_q  [3][QUAT_LANES];

    logic signed [TP_W-1:0] r_tp [VEC_LANES][2];
    logic signed [T_W-1:0]  r_t  [VEC_LANES];
    logic signed [UP_W-1:0] r_up [VEC_LANES][3];
    logic signed [U_W-1:0]  r_u  [VEC_LANES];
    logic [VEC_LANES*LANE_W-1:0] r_tr;
    logic                        r_ovf;

    logic signed [T_W-1:0]      n_t   [VEC_LANES];
    logic signed [U_W-1:0]      n_u   [VEC_LANES];
    logic [VEC_LANES*LANE_W-1:0] n_tr;
    logic                        n_ovf;

    always_comb begin
        for (int i = 0; i < VEC_LANES; i++) begin
            w_ct[i] = i_child_translation[LANE_W*i +: LANE_W];
            w_ps[i] = i_parent_scale[LANE_W*i +: LANE_W];
            w_pt[i] = i_parent_translation[LANE_W*i +: LANE_W];
        end
        for (int i = 0; i < QUAT_LANES; i++) begin
            w_pq[i] = i_parent_rotation[LANE_W*i +: LANE_W];
        end
    end

    // t = round(q x v); u = round(2 * (w*t + q x t)); out = round(v + u + pt*256)
    always_comb begin
        logic signed [TP_W-1:0]     tdiff;
        logic signed [US_W-1:0]     usum;
        logic signed [SAT_IN_W-1:0] fsum;
        t_sat                       s;
        n_ovf = 1'b0;
        for (int i = 0; i < VEC_LANES; i++) begin
            tdiff  = r_tp[i][0] - r_tp[i][1] + TP_W'(1 << (Q_SHIFT - 1));
            n_t[i] = T_W'(tdiff >>> Q_SHIFT);
            usum   = US_W'(r_up[i][0]) + US_W'(r_up[i][1]) - US_W'(r_up[i][2]);
            usum   = (usum <<< 1) + US_W'(1 << (Q_SHIFT - 1));
            n_u[i] = U_W'(usum >>> Q_SHIFT);
            fsum   = SAT_IN_W'(r_v[4][i]) + SAT_IN_W'(r_u[i])
                   + (SAT_IN_W'(r_pt[4][i]) <<< QS_SHIFT)
                   + SAT_IN_W'(1 << (QS_SHIFT - 1));
            s      = sat16(fsum >>> QS_SHIFT);
            n_tr[LANE_W*i +: LANE_W] = s.val;
            n_ovf  = n_ovf | s.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        // Stage 0: scale the child translation
        if (i_ctl.ld[0]) begin
            for (int i = 0; i < VEC_LANES; i++) begin
                r_v[0][i]  <= w_ps[i] * w_ct[i];
                r_pt[0][i] <= w_pt[i];
            end
            for (int i = 0; i < QUAT_LANES; i++) begin
                r_q[0][i] <= w_pq[i];
            end
        end
        // Stage 1: cross-product terms of q x v
        if (i_ctl.ld[1]) begin
            r_tp[0][0] <= r_q[0][2] * r_v[0][2];
            r_tp[0][1] <= r_q[0][3] * r_v[0][1];
            r_tp[1][0] <= r_q[0][3] * r_v[0][0];
            r_tp[1][1] <= r_q[0][1] * r_v[0][2];
            r_tp[2][0] <= r_q[0][1] * r_v[0][1];
            r_tp[2][1] <= r_q[0][2] * r_v[0][0];
        end
        // Stage 2: round t
        if (i_ctl.ld[2]) begin
            r_t <= n_t;
        end
        // Stage 3: terms of w*t + q x t
        if (i_ctl.ld[3]) begin
            r_up[0][0] <= r_q[2][0] * r_t[0];
            r_up[0][1] <= r_q[2][2] * r_t[2];
            r_up[0][2] <= r_q[2][3] * r_t[1];
            r_up[1][0] <= r_q[2][0] * r_t[1];
            r_up[1][1] <= r_q[2][3] * r_t[0];
            r_up[1][2] <= r_q[2][1] * r_t[2];
            r_up[2][0] <= r_q[2][0] * r_t[2];
            r_up[2][1] <= r_q[2][1] * r_t[1];
            r_up[2][2] <= r_q[2][2] * r_t[0];
        end
        // Stage 4: round u
        if (i_ctl.ld[4]) begin
            r_u <= n_u;
        end
        // Stage 5: final sum and clamp
        if (i_ctl.ld[5]) begin
            r_tr  <= n_tr;
            r_ovf <= n_ovf;
        end
        // Advance carried operands
        for (int k = 1; k < NUM_STAGES - 1; k++) begin
            if (i_ctl.ld[k]) begin
                r_v[k]  <= r_v[k-1];
                r_pt[k] <= r_pt[k-1];
            end
        end
        for (int k = 1; k < 3; k++) begin
            if (i_ctl.ld[k]) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_translation = r_tr;
    assign o_overflow    = r_ovf;

endmodule

>>> rtl/core/trs_transform_compose_unit.sv
`timescale 1ns / 1ps
// Top level of the TRS transform compose block: handshake, scale and
// rotation paths, output register. Uses trs_pkg and trs_vrot.
//
// Usage:
//   Input channel: i_valid / o_stall. An item (child and parent transform)
//   is taken at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall. The composed transform and the
//   overflow flag are taken at a rising edge with o_valid high and
//   i_stall low. Fields are signed Q8.8 (translation, scale) and Q1.14
//   (rotation) lanes, x or w in the low bits.
//   Pipeline: six register stages, set by the translation path (scale
//   multiply, q x v multiply, round, q x t multiply, round, final add and
//   clamp), one stage each.
//   Throughput: one item per cycle while i_stall is low; the six stages are
//   independent and hold no state between items.
//   Reset (i_rst_n low, synchronous) empties every stage; payload
//   registers keep whatever they held.
//   Stall: while i_stall is high the output item holds still; empty
//   stages further back keep filling, and o_stall rises only when all
//   six stages hold an item.
module trs_transform_compose_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [trs_pkg::VEC_LANES*trs_pkg::LANE_W-1:0]  i_child_translation,
    input  logic [trs_pkg::QUAT_LANES*trs_pkg::LANE_W-1:0] i_child_rotation,
    input  logic [trs_pkg::VEC_LANES*trs_pkg::LANE_W-1:0]  i_child_scale,
    input  logic [trs_pkg::VEC_LANES*trs_pkg::LANE_W-1:0]  i_parent_translation,
    input  logic [trs_pkg::QUAT_LANES*trs_pkg::LANE_W-1:0] i_parent_rotation,
    input  logic [trs_pkg::VEC_LANES*trs_pkg::LANE_W-1:0]  i_parent_scale,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [trs_pkg::VEC_LANES*trs_pkg::LANE_W-1:0]  o_out_translation,
    output logic [trs_pkg::QUAT_LANES*trs_pkg::LANE_W-1:0] o_out_rotation,
    output logic [trs_pkg::VEC_LANES*trs_pkg::LANE_W-1:0]  o_out_scale,
    output logic                                   o_overflow
);
    import trs_pkg::*;

    // ---------------- pipeline control ----------------
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_rdy;
    t_pipe_ctl             w_ctl;

    // A stage may load when it is empty or its contents move on this cycle
    always_comb begin
        w_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_ctl.ld = w_rdy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    // ---------------- scale and rotation ----------------
    t_lane w_cs [VEC_LANES];
    t_lane w_ps [VEC_LANES];
    t_lane w_cq [QUAT_LANES];
    t_lane w_pq [QUAT_LANES];

    always_comb begin
        for (int i = 0; i < VEC_LANES; i++) begin
            w_cs[i] = i_child_scale[LANE_W*i +: LANE_W];
            w_ps[i] = i_parent_scale[LANE_W*i +: LANE_W];
        end
        for (int i = 0; i < QUAT_LANES; i++) begin
            w_cq[i] = i_child_rotation[LANE_W*i +: LANE_W];
            w_pq[i] = i_parent_rotation[LANE_W*i +: LANE_W];
        end
    end

    // Stage 0 products: per-axis scale and all sixteen parent x child terms
    logic signed [PROD_W-1:0] r_sp [VEC_LANES];
    logic signed [PROD_W-1:0] r_rp [QUAT_LANES][QUAT_LANES];

    // Stages 1..5 carry the finished scale, rotation and their clamp flag
    logic [VEC_LANES*LANE_W-1:0]  r_sc_d  [1:NUM_STAGES-1];
    logic [QUAT_LANES*LANE_W-1:0] r_rot_d [1:NUM_STAGES-1];
    logic                         r_ovf_d [1:NUM_STAGES-1];

    logic [VEC_LANES*LANE_W-1:0]  n_sc;
    logic [QUAT_LANES*LANE_W-1:0] n_rot;
    logic                         n_ovf;

    // Round, Hamilton-sum and clamp the stage 0 products
    always_comb begin
        logic signed [SC_SUM_W-1:0]  ssum;
        logic signed [ROT_SUM_W-1:0] rsum [QUAT_LANES];
        t_sat                        s;
        n_ovf = 1'b0;
        for (int i = 0; i < VEC_LANES; i++) begin
            ssum = SC_SUM_W'(r_sp[i]) + SC_SUM_W'(1 << (QS_SHIFT - 1));
            s    = sat16(SAT_IN_W'(ssum >>> QS_SHIFT));
            n_sc[LANE_W*i +: LANE_W] = s.val;
            n_ovf = n_ovf | s.ovf;
        end
        rsum[0] = ROT_SUM_W'(r_rp[0][0]) - ROT_SUM_W'(r_rp[1][1])
                - ROT_SUM_W'(r_rp[2][2]) - ROT_SUM_W'(r_rp[3][3]);
        rsum[1] = ROT_SUM_W'(r_rp[0][1]) + ROT_SUM_W'(r_rp[1][0])
                + ROT_SUM_W'(r_rp[2][3]) - ROT_SUM_W'(r_rp[3][2]);
        rsum[2] = ROT_SUM_W'(r_rp[0][2]) - ROT_SUM_W'(r_rp[1][3])
                + ROT_SUM_W'(r_rp[2][0]) + ROT_SUM_W'(r_rp[3][1]);
        rsum[3] = ROT_SUM_W'(r_rp[0][3]) + ROT_SUM_W'(r_rp[1][2])
                - ROT_SUM_W'(r_rp[2][1]) + ROT_SUM_W'(r_rp[3][0]);
        for (int i = 0; i < QUAT_LANES; i++) begin
            rsum[i] = rsum[i] + ROT_SUM_W'(1 << (Q_SHIFT - 1));
            s       = sat16(SAT_IN_W'(rsum[i] >>> Q_SHIFT));
            n_rot[LANE_W*i +: LANE_W] = s.val;
            n_ovf   = n_ovf | s.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int i = 0; i < VEC_LANES; i++) begin
                r_sp[i] <= w_cs[i] * w_ps[i];
            end
            for (int i = 0; i < QUAT_LANES; i++) begin
                for (int j = 0; j < QUAT_LANES; j++) begin
                    r_rp[i][j] <= w_pq[i] * w_cq[j];
                end
            end
        end
        if (w_rdy[1]) begin
            r_sc_d[1]  <= n_sc;
            r_rot_d[1] <= n_rot;
            r_ovf_d[1] <= n_ovf;
        end
        // Hold finished lanes alongside the translation path
        for (int k = 2; k < NUM_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_sc_d[k]  <= r_sc_d[k-1];
                r_rot_d[k] <= r_rot_d[k-1];
                r_ovf_d[k] <= r_ovf_d[k-1];
            end
        end
    end

    // ---------------- translation ----------------
    logic [VEC_LANES*LANE_W-1:0] w_tr;
    logic                        w_tr_ovf;

    trs_vrot u_vrot (
        .i_clk                (i_clk),
        .i_ctl                (w_ctl),
        .i_child_translation  (i_child_translation),
        .i_parent_scale       (i_parent_scale),
        .i_parent_translation (i_parent_translation),
        .i_parent_rotation    (i_parent_rotation),
        .o_translation        (w_tr),
        .o_overflow           (w_tr_ovf)
    );

    assign o_out_translation = w_tr;
    assign o_out_rotation    = r_rot_d[NUM_STAGES-1];
    assign o_out_scale       = r_sc_d[NUM_STAGES-1];
    assign o_overflow        = r_ovf_d[NUM_STAGES-1] | w_tr_ovf;

    // ---------------- checks ----------------
    logic w_any_rail;

    always_comb begin
        w_any_rail = 1'b0;
        for (int i = 0; i < VEC_LANES; i++) begin
            w_any_rail = w_any_rail
                || o_out_translation[LANE_W*i +: LANE_W] == LANE_MAX
                || o_out_translation[LANE_W*i +: LANE_W] == LANE_MIN
                || o_out_scale[LANE_W*i +: LANE_W] == LANE_MAX
                || o_out_scale[LANE_W*i +: LANE_W] == LANE_MIN;
        end
        for (int i = 0; i < QUAT_LANES; i++) begin
            w_any_rail = w_any_rail
                || o_out_rotation[LANE_W*i +: LANE_W] == LANE_MAX
                || o_out_rotation[LANE_W*i +: LANE_W] == LANE_MIN;
        end
    end

    // Back-pressure reaches the input only with a full pipe and a stalled output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && r_vld == '1))
        else $error("input stalled while the pipe had room");

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("item survived reset");

    // An item in the last inner stage moves to the output when it has room
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NUM_STAGES-2] && w_rdy[NUM_STAGES-1]) |=> o_valid)
        else $error("item lost before the output register");

    // A flagged item has at least one lane on a rail
    a_ovf_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> w_any_rail)
        else $error("overflow flag without a clamped lane");

endmodule
